// File: rtl/srb_pkg.sv
package srb_pkg;

    localparam int BYTE_W = 8;
    localparam int LEN_W  = 12;
    localparam int HEAD_W = 7;

    localparam int DEF_CAPACITY    = 4096;
    localparam int DEF_MAX_SEGMENT = 2048;
    localparam int DEF_MAX_REQUEST = 64;

    typedef enum logic [1:0] {
        MODE_STORE = 2'd0,
        MODE_FETCH = 2'd1,
        MODE_PEEK  = 2'd2,
        MODE_HEAD  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOTHING = 2'd1,
        ST_OVERRUN = 2'd2,
        ST_LONG    = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TAKE,
        S_APPLY,
        S_FINISH,
        S_STREAM
    } state_t;

    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic             atomic;
        logic             limit_small;
    } take_req_t;

    typedef struct packed {
        logic [LEN_W-1:0] grant;
        status_t          st;
        logic             wrap;
        logic [LEN_W-1:0] rest;
    } take_res_t;

endpackage

// File: rtl/segment_ring_buffer_top.sv
// Contiguous-segment byte ring buffer over one single-port-write, registered-read
// memory of 2*MAX_SEGMENT+CAPACITY bytes. A store word (mode 0) is taken every
// cycle while idle and its result word shows on the following cycle; busy stays
// low. A fetch, peek or header fetch holds busy through the take, apply and finish
// states of pointer arithmetic in the shared take unit (take and apply twice for a
// header fetch that also discards the record), then through the stream state while
// bytes are copied, paced by the memory read port; byte words follow one per cycle,
// each registered with its read data. A request that copies no byte returns a
// single result word. Results are strobed for one cycle and cannot be held off.
// Memory contents are undefined until written; there is no clearing pass after reset.
module segment_ring_buffer_top #(
    parameter int CAPACITY    = srb_pkg::DEF_CAPACITY,
    parameter int MAX_SEGMENT = srb_pkg::DEF_MAX_SEGMENT,
    parameter int MAX_REQUEST = srb_pkg::DEF_MAX_REQUEST
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  mode,
    input  logic [srb_pkg::BYTE_W-1:0]  data_byte,
    input  logic [srb_pkg::LEN_W-1:0]   length,
    input  logic [srb_pkg::HEAD_W-1:0]  head_length,
    input  logic                        first,
    input  logic                        last,
    input  logic                        copy,
    input  logic                        atomic,
    output logic                        strobe,
    output logic [srb_pkg::BYTE_W-1:0]  out_byte,
    output logic                        byte_valid,
    output logic [srb_pkg::LEN_W-1:0]   granted,
    output logic [1:0]                  status,
    output logic                        done_res
);
    import srb_pkg::*;

    localparam int TOTAL = 2 * MAX_SEGMENT + CAPACITY;
    localparam int RP_W  = $clog2(TOTAL);
    localparam int WP_W  = $clog2(TOTAL + 1);
    localparam int SC_W  = $clog2(CAPACITY + (1 << LEN_W));
    localparam int CAP_W = $clog2(CAPACITY + 1);
    localparam int REQ_W = $clog2(MAX_REQUEST + 1);
    localparam int CMP_A = (WP_W > SC_W) ? WP_W : SC_W;
    localparam int CMP_B = (CAP_W > LEN_W) ? CAP_W : LEN_W;
    localparam int CMP_W = (CMP_A > CMP_B) ? CMP_A : CMP_B;
    localparam int SUM_W = CMP_W + 1;

    state_t state_reg, state_next;

    // pointer and segment state
    logic [RP_W-1:0]  read_pos_reg, read_pos_next;
    logic [WP_W-1:0]  write_pos_reg, write_pos_next;
    logic [WP_W-1:0]  data_end_reg, data_end_next;
    logic [SC_W-1:0]  stored_count_reg, stored_count_next;
    logic             seg_open_reg, seg_open_next;
    logic             seg_refused_reg, seg_refused_next;
    logic [LEN_W-1:0] seg_count_reg, seg_count_next;
    logic [LEN_W-1:0] seg_len_reg, seg_len_next;

    // request context
    mode_t            mode_q_reg, mode_q_next;
    logic             copy_q_reg, copy_q_next;
    logic             atomic_q_reg, atomic_q_next;
    logic [LEN_W-1:0] len1_reg, len1_next;
    logic [LEN_W-1:0] len2_reg, len2_next;
    logic             hdr_fits_reg, hdr_fits_next;
    logic             phase2_reg, phase2_next;
    take_res_t        tk_reg, tk_next;
    logic [LEN_W-1:0] g1_reg, g1_next;
    status_t          st1_reg, st1_next;
    logic [LEN_W-1:0] g2_reg, g2_next;
    logic             flag2_reg, flag2_next;
    logic [LEN_W-1:0] fin_granted_reg, fin_granted_next;
    status_t          fin_status_reg, fin_status_next;
    logic [RP_W-1:0]  strm_addr_reg, strm_addr_next;
    logic             strm_wrap_reg, strm_wrap_next;
    logic [LEN_W-1:0] to_wrap_reg, to_wrap_next;
    logic [REQ_W-1:0] issue_left_reg, issue_left_next;

    // result word
    logic             strobe_reg, strobe_next;
    logic             byte_valid_reg, byte_valid_next;
    logic [LEN_W-1:0] granted_reg, granted_next;
    status_t          status_reg, status_next;
    logic             done_reg, done_next;

    mode_t            mode_in;
    logic             accept;
    take_req_t        tk_req;
    take_res_t        tk_out;
    logic             go_phase2;
    logic [RP_W-1:0]  tk_rp_new;
    logic [LEN_W-1:0] fin_sum;
    logic [REQ_W-1:0] fin_nb;
    status_t          fin_st;

    // store path
    logic             s_open;
    logic             s_refused;
    logic [LEN_W-1:0] s_count;
    logic [LEN_W-1:0] s_len;
    logic             s_wrap;
    logic [WP_W-1:0]  s_wp;
    logic [WP_W-1:0]  s_de;
    logic             s_write;
    status_t          s_st;

    logic              mem_wr_en;
    logic              rd_en;
    logic [BYTE_W-1:0] rd_data;

    assign mode_in = mode_t'(mode);
    assign accept  = start && !busy;

    srb_take #(
        .CAPACITY    (CAPACITY),
        .MAX_SEGMENT (MAX_SEGMENT),
        .MAX_REQUEST (MAX_REQUEST)
    ) u_take (
        .req          (tk_req),
        .read_pos     (read_pos_reg),
        .write_pos    (write_pos_reg),
        .data_end     (data_end_reg),
        .stored_count (stored_count_reg),
        .res          (tk_out)
    );

    srb_mem #(
        .DEPTH (TOTAL)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (s_wp[RP_W-1:0]),
        .wr_data (data_byte),
        .rd_en   (rd_en),
        .rd_addr (strm_addr_reg),
        .rd_data (rd_data)
    );

    // store word: open/refuse segment, wrap to address 0 if it would run off the end
    always_comb
    begin
        s_open    = seg_open_reg || first;
        s_count   = first ? '0 : seg_count_reg;
        s_len     = first ? length : seg_len_reg;
        s_refused = first ? (CMP_W'(stored_count_reg) >= CMP_W'(CAPACITY)) : seg_refused_reg;
        s_wrap    = first && !s_refused
                    && ((SUM_W'(write_pos_reg) + SUM_W'(length)) > SUM_W'(TOTAL));
        s_wp      = s_wrap ? '0 : write_pos_reg;
        s_de      = s_wrap ? write_pos_reg : data_end_reg;
        s_write   = s_open && !s_refused && (s_count < s_len) && (CMP_W'(s_wp) < CMP_W'(TOTAL));
        if (!s_open)
        begin
            s_st = ST_NOTHING;
        end
        else if (s_refused)
        begin
            s_st = ST_OVERRUN;
        end
        else if (s_write)
        begin
            s_st = ST_OK;
        end
        else
        begin
            s_st = ST_NOTHING;
        end
    end

    assign mem_wr_en = accept && (mode_in == MODE_STORE) && s_write;

    // second take of a header fetch only when the header went through whole
    assign go_phase2 = !phase2_reg && (mode_q_reg == MODE_HEAD) && (tk_reg.st != ST_LONG)
                       && (tk_reg.grant == len1_reg) && hdr_fits_reg;

    assign tk_rp_new = tk_reg.wrap ? RP_W'(tk_reg.grant - tk_reg.rest)
                                   : RP_W'(CMP_W'(read_pos_reg) + CMP_W'(tk_reg.grant));

    assign fin_sum = g1_reg + g2_reg;
    assign fin_nb  = ((mode_q_reg == MODE_FETCH) && !copy_q_reg) ? '0 : REQ_W'(g1_reg);

    always_comb
    begin
        if (mode_q_reg == MODE_HEAD)
        begin
            if ((st1_reg == ST_LONG) || flag2_reg)
            begin
                fin_st = ST_LONG;
            end
            else if (fin_sum == '0)
            begin
                fin_st = ST_NOTHING;
            end
            else
            begin
                fin_st = ST_OK;
            end
        end
        else
        begin
            fin_st = st1_reg;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start && (mode_in != MODE_STORE))
                begin
                    state_next = S_TAKE;
                end
            end
            S_TAKE:
            begin
                state_next = S_APPLY;
            end
            S_APPLY:
            begin
                state_next = go_phase2 ? S_TAKE : S_FINISH;
            end
            S_FINISH:
            begin
                state_next = (fin_nb == '0) ? S_IDLE : S_STREAM;
            end
            S_STREAM:
            begin
                if (issue_left_reg == REQ_W'(1))
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // FSM outputs
    always_comb
    begin
        busy               = (state_reg != S_IDLE);
        rd_en              = (state_reg == S_STREAM);
        tk_req.len         = phase2_reg ? len2_reg : len1_reg;
        tk_req.atomic      = phase2_reg || (mode_q_reg == MODE_HEAD) || atomic_q_reg;
        tk_req.limit_small = !phase2_reg && ((mode_q_reg != MODE_FETCH) || copy_q_reg);
    end

    // datapath
    always_comb
    begin
        read_pos_next     = read_pos_reg;
        write_pos_next    = write_pos_reg;
        data_end_next     = data_end_reg;
        stored_count_next = stored_count_reg;
        seg_open_next     = seg_open_reg;
        seg_refused_next  = seg_refused_reg;
        seg_count_next    = seg_count_reg;
        seg_len_next      = seg_len_reg;
        mode_q_next       = mode_q_reg;
        copy_q_next       = copy_q_reg;
        atomic_q_next     = atomic_q_reg;
        len1_next         = len1_reg;
        len2_next         = len2_reg;
        hdr_fits_next     = hdr_fits_reg;
        phase2_next       = phase2_reg;
        tk_next           = tk_reg;
        g1_next           = g1_reg;
        st1_next          = st1_reg;
        g2_next           = g2_reg;
        flag2_next        = flag2_reg;
        fin_granted_next  = fin_granted_reg;
        fin_status_next   = fin_status_reg;
        strm_addr_next    = strm_addr_reg;
        strm_wrap_next    = strm_wrap_reg;
        to_wrap_next      = to_wrap_reg;
        issue_left_next   = issue_left_reg;
        strobe_next       = 1'b0;
        byte_valid_next   = byte_valid_reg;
        granted_next      = granted_reg;
        status_next       = status_reg;
        done_next         = done_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    mode_q_next   = mode_in;
                    copy_q_next   = copy;
                    atomic_q_next = atomic;
                    len1_next     = (mode_in == MODE_HEAD) ? LEN_W'(head_length) : length;
                    len2_next     = length - LEN_W'(head_length);
                    hdr_fits_next = (length >= LEN_W'(head_length));
                    phase2_next   = 1'b0;
                    g2_next       = '0;
                    flag2_next    = 1'b0;
                    if (mode_in == MODE_STORE)
                    begin
                        seg_open_next    = last ? 1'b0 : s_open;
                        seg_refused_next = s_refused;
                        seg_len_next     = s_len;
                        seg_count_next   = s_write ? (s_count + LEN_W'(1)) : s_count;
                        write_pos_next   = s_write ? (s_wp + WP_W'(1)) : s_wp;
                        data_end_next    = s_de;
                        if (s_write)
                        begin
                            stored_count_next = stored_count_reg + SC_W'(1);
                        end
                        strobe_next     = 1'b1;
                        byte_valid_next = 1'b0;
                        granted_next    = s_write ? LEN_W'(1) : '0;
                        status_next     = s_st;
                        done_next       = 1'b1;
                    end
                end
            end
            S_TAKE:
            begin
                tk_next = tk_out;
            end
            S_APPLY:
            begin
                if ((mode_q_reg != MODE_PEEK) && (tk_reg.st == ST_OK))
                begin
                    read_pos_next     = tk_rp_new;
                    stored_count_next = stored_count_reg - SC_W'(tk_reg.grant);
                    if (tk_reg.wrap)
                    begin
                        data_end_next = WP_W'(TOTAL);
                    end
                end
                if (!phase2_reg)
                begin
                    g1_next  = tk_reg.grant;
                    st1_next = tk_reg.st;
                    // copy starts at the old read position, or at 0 if already at the mark
                    strm_addr_next = (tk_reg.wrap && (tk_reg.rest == '0)) ? '0 : read_pos_reg;
                    strm_wrap_next = tk_reg.wrap && (tk_reg.rest != '0);
                    to_wrap_next   = tk_reg.rest;
                end
                else
                begin
                    g2_next    = tk_reg.grant;
                    flag2_next = (tk_reg.st == ST_LONG);
                end
                if (go_phase2)
                begin
                    phase2_next = 1'b1;
                end
            end
            S_FINISH:
            begin
                fin_granted_next = fin_sum;
                fin_status_next  = fin_st;
                issue_left_next  = fin_nb;
                if (fin_nb == '0)
                begin
                    strobe_next     = 1'b1;
                    byte_valid_next = 1'b0;
                    granted_next    = fin_sum;
                    status_next     = fin_st;
                    done_next       = 1'b1;
                end
            end
            S_STREAM:
            begin
                if (strm_wrap_reg && (to_wrap_reg == LEN_W'(1)))
                begin
                    strm_addr_next = '0;
                    strm_wrap_next = 1'b0;
                end
                else
                begin
                    strm_addr_next = strm_addr_reg + RP_W'(1);
                end
                to_wrap_next    = to_wrap_reg - LEN_W'(1);
                issue_left_next = issue_left_reg - REQ_W'(1);
                // byte word lands in the next cycle, with the read data
                strobe_next     = 1'b1;
                byte_valid_next = 1'b1;
                granted_next    = fin_granted_reg;
                status_next     = fin_status_reg;
                done_next       = (issue_left_reg == REQ_W'(1));
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            read_pos_reg     <= '0;
            write_pos_reg    <= '0;
            data_end_reg     <= WP_W'(TOTAL);
            stored_count_reg <= '0;
            seg_open_reg     <= 1'b0;
            seg_refused_reg  <= 1'b0;
            seg_count_reg    <= '0;
            seg_len_reg      <= '0;
            strobe_reg       <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            read_pos_reg     <= read_pos_next;
            write_pos_reg    <= write_pos_next;
            data_end_reg     <= data_end_next;
            stored_count_reg <= stored_count_next;
            seg_open_reg     <= seg_open_next;
            seg_refused_reg  <= seg_refused_next;
            seg_count_reg    <= seg_count_next;
            seg_len_reg      <= seg_len_next;
            strobe_reg       <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_q_reg      <= mode_q_next;
        copy_q_reg      <= copy_q_next;
        atomic_q_reg    <= atomic_q_next;
        len1_reg        <= len1_next;
        len2_reg        <= len2_next;
        hdr_fits_reg    <= hdr_fits_next;
        phase2_reg      <= phase2_next;
        tk_reg          <= tk_next;
        g1_reg          <= g1_next;
        st1_reg         <= st1_next;
        g2_reg          <= g2_next;
        flag2_reg       <= flag2_next;
        fin_granted_reg <= fin_granted_next;
        fin_status_reg  <= fin_status_next;
        strm_addr_reg   <= strm_addr_next;
        strm_wrap_reg   <= strm_wrap_next;
        to_wrap_reg     <= to_wrap_next;
        issue_left_reg  <= issue_left_next;
        byte_valid_reg  <= byte_valid_next;
        granted_reg     <= granted_next;
        status_reg      <= status_next;
        done_reg        <= done_next;
    end

    assign strobe     = strobe_reg;
    assign byte_valid = byte_valid_reg;
    assign out_byte   = byte_valid_reg ? rd_data : '0;
    assign granted    = granted_reg;
    assign status     = status_reg;
    assign done_res   = done_reg;

`ifndef SYNTHESIS
    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_wr_en && rd_en))
        else $error("memory read and write in the same cycle");

    a_nobyte_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !byte_valid |-> done_res)
        else $error("result word without a byte is not the last one");

    a_stream_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_STREAM) |-> (issue_left_reg != '0))
        else $error("streaming with no bytes left");

    a_request_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (mode_t'(mode) != MODE_STORE) |=> busy)
        else $error("request accepted but block not busy");

    a_bytes_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && byte_valid && !done_res |=> strobe && byte_valid)
        else $error("gap inside a run of byte words");
`endif

endmodule

// File: rtl/srb_mem.sv
module srb_mem #(
    parameter int DEPTH = 2 * srb_pkg::DEF_MAX_SEGMENT + srb_pkg::DEF_CAPACITY
) (
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic [$clog2(DEPTH)-1:0]    wr_addr,
    input  logic [srb_pkg::BYTE_W-1:0]  wr_data,
    input  logic                        rd_en,
    input  logic [$clog2(DEPTH)-1:0]    rd_addr,
    output logic [srb_pkg::BYTE_W-1:0]  rd_data
);
    import srb_pkg::*;

    logic [BYTE_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: rtl/srb_take.sv
module srb_take #(
    parameter int CAPACITY    = srb_pkg::DEF_CAPACITY,
    parameter int MAX_SEGMENT = srb_pkg::DEF_MAX_SEGMENT,
    parameter int MAX_REQUEST = srb_pkg::DEF_MAX_REQUEST
) (
    input  srb_pkg::take_req_t req,
    input  logic [$clog2(2*MAX_SEGMENT+CAPACITY)-1:0]   read_pos,
    input  logic [$clog2(2*MAX_SEGMENT+CAPACITY+1)-1:0] write_pos,
    input  logic [$clog2(2*MAX_SEGMENT+CAPACITY+1)-1:0] data_end,
    input  logic [$clog2(CAPACITY+(1<<srb_pkg::LEN_W))-1:0] stored_count,
    output srb_pkg::take_res_t res
);
    import srb_pkg::*;

    localparam int TOTAL  = 2 * MAX_SEGMENT + CAPACITY;
    localparam int WP_W   = $clog2(TOTAL + 1);
    localparam int SC_W   = $clog2(CAPACITY + (1 << LEN_W));
    localparam int CAP_W  = $clog2(CAPACITY + 1);
    localparam int CMP_A  = (WP_W > SC_W) ? WP_W : SC_W;
    localparam int CMP_B  = (CAP_W > LEN_W) ? CAP_W : LEN_W;
    localparam int CMP_W  = (CMP_A > CMP_B) ? CMP_A : CMP_B;

    logic             empty;
    logic             over;
    logic [LEN_W-1:0] cut;
    logic [CMP_W-1:0] limit;
    logic [CMP_W-1:0] rp_x;
    logic [CMP_W-1:0] rest_full;

    assign empty = (WP_W'(read_pos) == write_pos);
    assign over  = (CMP_W'(req.len) > CMP_W'(stored_count));
    // when over, the stored count is below the request and fits the length width
    assign cut   = over ? LEN_W'(stored_count) : req.len;
    assign limit = req.limit_small ? CMP_W'(MAX_REQUEST) : CMP_W'(CAPACITY);
    assign rp_x  = CMP_W'(read_pos);
    // bytes left before the end-of-data mark, zero when already at or past it
    assign rest_full = (CMP_W'(data_end) > rp_x) ? (CMP_W'(data_end) - rp_x) : '0;

    always_comb
    begin
        res.rest  = LEN_W'(rest_full);
        res.wrap  = (rest_full <= CMP_W'(cut));
        res.grant = '0;
        res.st    = ST_OK;
        if ((req.atomic && over) || empty)
        begin
            res.st = ST_NOTHING;
        end
        else if (CMP_W'(cut) > limit)
        begin
            res.st = ST_LONG;
        end
        else
        begin
            res.grant = cut;
        end
    end

endmodule
